@@ hdl/assert_macros.svh @@
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion clocked on i_clk, off during reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// concurrent assertion clocked on i_clk, checked in reset too
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hdl/glog_pkg.sv @@
// shared types, constants and a helper function of the edge filter
package glog_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int MIN_DIM     = 5;
    localparam int LINES       = 4;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int DIM_W       = 12;
    localparam int POS_W       = 11;
    localparam int WIN         = 5;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 12'd480;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0]       edge_value;
        logic [POS_W-1:0] centre_column;
        logic [POS_W-1:0] centre_row;
        logic             last_of_frame;
    } t_result;

    typedef struct packed {
        logic             emit;
        logic             last;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } t_pos_info;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        res = v;
        if (v < DIM_W'(MIN_DIM)) res = DIM_W'(MIN_DIM);
        else if (v > hi) res = hi;
        return res;
    endfunction

endpackage

@@ hdl/glog_column_cell.sv @@
// one window column cell: holds five grey pixels and passes them to its neighbor
module glog_column_cell (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [glog_pkg::WIN*8-1:0] i_col,
    output logic [glog_pkg::WIN*8-1:0] o_col
);
    import glog_pkg::*;

    logic [WIN*8-1:0] r_col;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;
endmodule

@@ hdl/glog_line_store.sv @@
// four grey line stores, one wide word per column
module glog_line_store (
    input  logic                                i_clk,
    input  logic                                i_ren,
    input  logic [glog_pkg::COL_W-1:0]          i_raddr,
    input  logic                                i_wen,
    input  logic [glog_pkg::COL_W-1:0]          i_waddr,
    input  logic [glog_pkg::LINES*8-1:0]        i_wdata,
    output logic [glog_pkg::LINES*8-1:0]        o_rdata
);
    import glog_pkg::*;

    logic [LINES*8-1:0] r_mem [MAX_WIDTH];
    logic [LINES*8-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ren) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/grey_log5x5_edge_filter.sv @@
// top level of the 5x5 laplacian-of-gaussian edge filter
//
//  channel   signals                      payload
//  pixel in  i_valid / o_ready            t_pixel: red, green, blue
//  result    o_valid / i_ready            t_result: edge, column, row, last
//  config    i_cfg_we, i_cfg_index/data   image_width, image_height
//
// one pixel per clock while the output is not stalled; registered steps after the
// pixel's accepting edge: grey and line store read, window shift and write-back, kernel sum.
// the line store word is read at the accepting edge and written back when stage 1 advances.
// reset clears counts and pipeline valids; line store contents stay undefined.
// a stalled output freezes the whole pipeline, so no transaction is lost.
module grey_log5x5_edge_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  glog_pkg::t_pixel            i_pixel,
    output logic                        o_valid,
    input  logic                        i_ready,
    output glog_pkg::t_result           o_result,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [glog_pkg::DIM_W-1:0]  i_cfg_data
);
    import glog_pkg::*;

    logic [DIM_W-1:0] r_width, r_height;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [DIM_W-1:0] r_colc, r_rowc;
    logic             adv, take;

    // stage 1: grey and position
    logic             r_v1;
    logic [7:0]       r_grey1;
    logic [COL_W-1:0] r_addr1;
    logic [1:0]       r_rsel1;
    t_pos_info        r_pos1;
    // stage 2: window
    logic             r_v2;
    t_pos_info        r_pos2;
    // stage 3: output
    logic             r_v3;
    t_result          r_out;

    logic [17:0] n_gsum;
    logic [DIM_W-1:0] col, row, n_colc, n_rowc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_IMAGE_WIDTH) r_width <= i_cfg_data;
            else r_height <= i_cfg_data;
        end
    end

    assign w_eff = clamp_dim(r_width, DIM_W'(MAX_WIDTH));
    assign h_eff = clamp_dim(r_height, DIM_W'(MAX_HEIGHT));

    assign adv     = !r_v3 || i_ready;
    assign o_ready = adv;
    assign take    = i_valid && adv;

    always_comb begin
        col = r_colc;
        row = r_rowc;
        if (col >= w_eff) begin
            col = '0;
            row = row + 1'b1;
        end
        if (row >= h_eff) row = '0;
        n_colc = col + 1'b1;
        n_rowc = row;
        if (n_colc >= w_eff) begin
            n_colc = '0;
            n_rowc = row + 1'b1;
            if (n_rowc >= h_eff) n_rowc = '0;
        end
        n_gsum = 18'(i_pixel.red) * 18'd307 + 18'(i_pixel.green) * 18'd604
               + 18'(i_pixel.blue) * 18'd113;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colc <= '0;
            r_rowc <= '0;
            r_v1   <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            if (take) begin
                r_colc <= n_colc;
                r_rowc <= n_rowc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_grey1        <= n_gsum[17:10];
            r_addr1        <= COL_W'(col);
            r_rsel1        <= row[1:0];
            r_pos1.emit    <= (row >= DIM_W'(4)) && (col >= DIM_W'(4));
            r_pos1.last    <= (col == w_eff - 1'b1) && (row == h_eff - 1'b1);
            r_pos1.col     <= POS_W'(col - DIM_W'(2));
            r_pos1.row     <= POS_W'(row - DIM_W'(2));
        end
    end

    // line store: window row k comes from slot (row + k) & 3; rotate by row
    logic [LINES*8-1:0] rdata, wdata;
    logic [7:0] lines [LINES];
    logic [7:0] newcol [WIN];
    logic [WIN*8-1:0] newcol_flat;
    logic en1;

    assign en1 = adv && r_v1;

    glog_line_store u_store (
        .i_clk   (i_clk),
        .i_ren   (take),
        .i_raddr (COL_W'(col)),
        .i_wen   (en1),
        .i_waddr (r_addr1),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    always_comb begin
        wdata = rdata;
        for (int k = 0; k < LINES; k++) begin
            lines[k] = rdata[k*8 +: 8];
        end
        wdata[r_rsel1*8 +: 8] = r_grey1;
        for (int k = 0; k < LINES; k++) begin
            newcol[k] = lines[2'(r_rsel1 + 2'(k))];
        end
        newcol[WIN-1] = r_grey1;
        for (int k = 0; k < WIN; k++) begin
            newcol_flat[k*8 +: 8] = newcol[k];
        end
    end

    // chain of column cells, cell 4 newest, cell 0 oldest
    logic [WIN*8-1:0] cols [WIN];
    logic [WIN*8-1:0] chain_in [WIN];

    genvar gi;
    generate
        for (gi = 0; gi < WIN; gi++) begin : g_cell
            if (gi == WIN-1) begin : g_head
                assign chain_in[gi] = newcol_flat;
            end else begin : g_link
                assign chain_in[gi] = cols[gi+1];
            end
            glog_column_cell u_cell (
                .i_clk (i_clk),
                .i_en  (en1),
                .i_col (chain_in[gi]),
                .o_col (cols[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1 && r_pos1.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) r_pos2 <= r_pos1;
    end

    // kernel: w[row][col] = cols[col][row*8 +: 8]
    function automatic logic signed [12:0] px(input logic [WIN*8-1:0] c, input int r);
        return 13'(c[r*8 +: 8]);
    endfunction

    logic signed [12:0] ksum;
    logic [7:0] kclamp;
    always_comb begin
        ksum = (px(cols[2], 2) <<< 4)
             - ((px(cols[2], 1) + px(cols[2], 3) + px(cols[1], 2) + px(cols[3], 2)) <<< 1)
             - (px(cols[1], 1) + px(cols[3], 1) + px(cols[1], 3) + px(cols[3], 3))
             - (px(cols[2], 0) + px(cols[2], 4) + px(cols[0], 2) + px(cols[4], 2));
        if (ksum < 0) kclamp = 8'd0;
        else if (ksum > 13'sd255) kclamp = 8'd255;
        else kclamp = ksum[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_v2) begin
            r_out.edge_value    <= kclamp;
            r_out.centre_column <= r_pos2.col;
            r_out.centre_row    <= r_pos2.row;
            r_out.last_of_frame <= r_pos2.last;
        end
    end

    assign o_valid  = r_v3;
    assign o_result = r_out;
endmodule

@@ hdl/glog_checker.sv @@
// port-level checker for the edge filter, bound to the top level
`include "assert_macros.svh"

module glog_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input glog_pkg::t_result          o_result
);
    import glog_pkg::*;

    `ASSERT_CLK(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_result),
        "result changed while stalled")
    `ASSERT_CLK(a_ready_free, !o_valid |-> o_ready, "input blocked with empty output")
    `ASSERT_CLK(a_stall_block, o_valid && !i_ready |-> !o_ready,
        "input taken while output stalled")
    `ASSERT_CLK(a_col_range, o_valid |-> o_result.centre_column >= POS_W'(2),
        "result column on border")
    `ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_valid, "result valid after reset")
endmodule

bind grey_log5x5_edge_filter glog_checker u_glog_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_result (o_result)
);
